// ===== design/bgp_message_deframer_core_macros.svh =====
// assertion macros for the message deframer
`ifndef BGP_MESSAGE_DEFRAMER_CORE_MACROS_SVH
`define BGP_MESSAGE_DEFRAMER_CORE_MACROS_SVH

// checked only while out of reset
`define BMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bmd_pkg.sv =====
package bmd_pkg;

  localparam int unsigned HeaderBytes = 19;
  localparam int unsigned MarkerBytes = 16;
  localparam int unsigned HdrIdxW     = $clog2(HeaderBytes);
  localparam int unsigned LenW        = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned OutDataW    = 32;

  localparam logic [ByteW-1:0]   MarkerFill = 8'hff;
  localparam logic [HdrIdxW-1:0] LastIdx    = HdrIdxW'(HeaderBytes - 1);
  localparam logic [HdrIdxW-1:0] LenHiIdx   = HdrIdxW'(MarkerBytes);
  localparam logic [HdrIdxW-1:0] LenLoIdx   = HdrIdxW'(MarkerBytes + 1);
  localparam logic [LenW-1:0]    HeaderLen  = LenW'(HeaderBytes);

  localparam logic [LenW-1:0] MinLenReset = 16'd19;
  localparam logic [LenW-1:0] MaxLenReset = 16'd4096;

  typedef enum logic {
    CFG_MIN_LEN = 1'b0,
    CFG_MAX_LEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_RELEASE,
    ST_BODY
  } state_e;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_ERROR = 1'b1
  } kind_e;

  // header byte coming back from the header ram
  typedef struct packed {
    logic               vld;
    logic [HdrIdxW-1:0] idx;
    logic [ByteW-1:0]   data;
  } hdr_rd_t;

endpackage

// ===== design/bmd_hdr_buf.sv =====
module bmd_hdr_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [bmd_pkg::HdrIdxW-1:0]  wr_addr_i,
  input  logic [bmd_pkg::ByteW-1:0]    wr_data_i,
  input  logic                         start_i,
  input  logic                         take_i,
  output bmd_pkg::hdr_rd_t             rd_o
);

  logic [bmd_pkg::ByteW-1:0]   mem_q [bmd_pkg::HeaderBytes];
  logic [bmd_pkg::HdrIdxW-1:0] iss_q, iss_d;
  logic                        active_q, active_d;
  logic                        vld_q, vld_d;
  logic [bmd_pkg::HdrIdxW-1:0] idx_q;
  logic [bmd_pkg::ByteW-1:0]   data_q;
  logic                        rd_en;

  assign rd_en = active_q && (!vld_q || take_i);

  always_comb begin
    iss_d    = iss_q;
    active_d = active_q;
    vld_d    = vld_q;
    if (start_i) begin
      iss_d    = '0;
      active_d = 1'b1;
    end else if (rd_en) begin
      iss_d = iss_q + 1'b1;
      vld_d = 1'b1;
      if (iss_q == bmd_pkg::LastIdx) begin
        active_d = 1'b0;
      end
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q    <= '0;
      active_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      iss_q    <= iss_d;
      active_q <= active_d;
      vld_q    <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      data_q <= mem_q[iss_q];
      idx_q  <= iss_q;
    end
  end

  assign rd_o.vld  = vld_q;
  assign rd_o.idx  = idx_q;
  assign rd_o.data = data_q;

endmodule

// ===== design/bgp_message_deframer_core.sv =====
// channel   dir  tdata (low bit up)                                  tuser  tlast
// s_axis    in   data_byte[7:0]                                      -      -
// m_axis    out  out_byte[7:0] first[8] end[9] msg_length[25:10]    kind   last_of_run
// cfg       in   cfg_idx_i 0 min_length, 1 max_length; cfg_data_i 16 bits, no read-back
//
// header bytes and body bytes are taken one per cycle while m_axis_tready does not stall them
// the 19th header byte, if the header passes, releases 19 transfers from the header ram:
//   read through the ram's output register, then one per cycle while not stalled; input is held off meanwhile
// a failed header gives one error transfer in the cycle after the 19th byte
// async active-low reset; length limits reset to 19 and 4096, the header ram needs no clearing
// an output register parts the sides; m_axis_tready low stalls release, body bytes and the 19th header byte
module bgp_message_deframer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // data_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bmd_pkg::OutDataW-1:0]    m_axis_tdata,   // out_byte, first, end, msg_length
  output logic                            m_axis_tuser,   // kind
  output logic                            m_axis_tlast,   // last_of_run
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [bmd_pkg::LenW-1:0]        cfg_data_i
);

  bmd_pkg::state_e               state_q, state_d;
  logic [bmd_pkg::LenW-1:0]      pos_q, pos_d;
  logic [bmd_pkg::LenW-1:0]      len_q, len_d;
  logic                          mark_ok_q, mark_ok_d;
  logic [bmd_pkg::LenW-1:0]      min_q, max_q;

  logic                          out_vld_q, out_vld_d;
  logic                          out_kind_q, out_kind_d;
  logic [bmd_pkg::ByteW-1:0]     out_byte_q, out_byte_d;
  logic                          out_first_q, out_first_d;
  logic                          out_end_q, out_end_d;
  logic [bmd_pkg::LenW-1:0]      out_len_q, out_len_d;
  logic                          out_last_q, out_last_d;
  logic                          load;

  logic                          free;
  logic                          in_fire;
  logic [bmd_pkg::HdrIdxW-1:0]   hunt_idx;
  logic                          hdr_bad;
  logic                          body_end;
  logic                          buf_wr;
  logic                          buf_start;
  logic                          buf_take;
  bmd_pkg::hdr_rd_t              rd;

  assign free     = !out_vld_q || m_axis_tready;
  assign hunt_idx = pos_q[bmd_pkg::HdrIdxW-1:0];

  always_comb begin
    s_axis_tready = 1'b0;
    case (state_q)
      bmd_pkg::ST_HUNT: s_axis_tready = (hunt_idx != bmd_pkg::LastIdx) || free;
      bmd_pkg::ST_BODY: s_axis_tready = free;
      default:          s_axis_tready = 1'b0;
    endcase
  end

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign hdr_bad  = !mark_ok_q || (len_q < bmd_pkg::HeaderLen) ||
                    (len_q < min_q) || (len_q > max_q);
  assign body_end = ({1'b0, pos_q} + 17'd1) >= {1'b0, len_q};
  assign buf_take = (state_q == bmd_pkg::ST_RELEASE) && free;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    len_d       = len_q;
    mark_ok_d   = mark_ok_q;
    buf_wr      = 1'b0;
    buf_start   = 1'b0;
    load        = 1'b0;
    out_kind_d  = bmd_pkg::KIND_BYTE;
    out_byte_d  = out_byte_q;
    out_first_d = 1'b0;
    out_end_d   = 1'b0;
    out_len_d   = len_q;
    out_last_d  = 1'b1;
    case (state_q)
      bmd_pkg::ST_HUNT: begin
        if (in_fire) begin
          buf_wr = 1'b1;
          pos_d  = pos_q + 1'b1;
          if (hunt_idx == '0) begin
            mark_ok_d = (s_axis_tdata == bmd_pkg::MarkerFill);
          end else if (hunt_idx < bmd_pkg::LenHiIdx) begin
            mark_ok_d = mark_ok_q && (s_axis_tdata == bmd_pkg::MarkerFill);
          end
          if (hunt_idx == bmd_pkg::LenHiIdx) begin
            len_d = {s_axis_tdata, len_q[7:0]};
          end
          if (hunt_idx == bmd_pkg::LenLoIdx) begin
            len_d = {len_q[15:8], s_axis_tdata};
          end
          if (hunt_idx == bmd_pkg::LastIdx) begin
            pos_d = '0;
            if (hdr_bad) begin
              load       = 1'b1;
              out_kind_d = bmd_pkg::KIND_ERROR;
              out_byte_d = '0;
            end else begin
              buf_start = 1'b1;
              state_d   = bmd_pkg::ST_RELEASE;
            end
          end
        end
      end
      bmd_pkg::ST_RELEASE: begin
        if (rd.vld && free) begin
          load        = 1'b1;
          out_byte_d  = rd.data;
          out_first_d = (rd.idx == '0);
          out_last_d  = (rd.idx == bmd_pkg::LastIdx);
          out_end_d   = (rd.idx == bmd_pkg::LastIdx) && (len_q == bmd_pkg::HeaderLen);
          if (rd.idx == bmd_pkg::LastIdx) begin
            if (len_q == bmd_pkg::HeaderLen) begin
              state_d = bmd_pkg::ST_HUNT;
              pos_d   = '0;
            end else begin
              state_d = bmd_pkg::ST_BODY;
              pos_d   = bmd_pkg::HeaderLen;
            end
          end
        end
      end
      bmd_pkg::ST_BODY: begin
        if (in_fire) begin
          load       = 1'b1;
          out_byte_d = s_axis_tdata;
          out_end_d  = body_end;
          if (body_end) begin
            state_d = bmd_pkg::ST_HUNT;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = bmd_pkg::ST_HUNT;
        pos_d   = '0;
      end
    endcase
  end

  assign out_vld_d = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bmd_pkg::ST_HUNT;
      pos_q     <= '0;
      len_q     <= '0;
      mark_ok_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      mark_ok_q <= mark_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= out_kind_d;
      out_byte_q  <= out_byte_d;
      out_first_q <= out_first_d;
      out_end_q   <= out_end_d;
      out_len_q   <= out_len_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= bmd_pkg::MinLenReset;
      max_q <= bmd_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      case (bmd_pkg::cfg_idx_e'(cfg_idx_i))
        bmd_pkg::CFG_MIN_LEN: min_q <= cfg_data_i;
        bmd_pkg::CFG_MAX_LEN: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bmd_hdr_buf u_hdr_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (buf_wr),
    .wr_addr_i (hunt_idx),
    .wr_data_i (s_axis_tdata),
    .start_i   (buf_start),
    .take_i    (buf_take),
    .rd_o      (rd)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'd0, out_len_q, out_end_q, out_first_q, out_byte_q};

endmodule

// ===== design/bmd_assert.sv =====
`include "bgp_message_deframer_core_macros.svh"

module bmd_assert (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [7:0]                   s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bmd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         m_axis_tlast,
  input logic                         cfg_we_i,
  input logic                         cfg_idx_i,
  input logic [bmd_pkg::LenW-1:0]     cfg_data_i
);

  `BMD_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "valid during reset")

  `BMD_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped while stalled")

  `BMD_ASSERT(a_err_shape, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[9:0] == 10'd0 && m_axis_tlast, "malformed error transfer")

  `BMD_ASSERT(a_end_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tlast && !m_axis_tuser, "message end not last of run")

  `BMD_ASSERT(a_first_not_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[8] |-> !m_axis_tlast && !m_axis_tuser, "first header byte closes a run")

endmodule

bind bgp_message_deframer_core bmd_assert u_bmd_assert (.*);
